>>> rtl/core/power_event_manager_macros.svh
// Assertion macros for the power event manager.
// Macros assume clk_i and rst_ni in the scope that uses them.
`ifndef POWER_EVENT_MANAGER_MACROS_SVH
`define POWER_EVENT_MANAGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PEM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pem_pkg.sv
// Shared types and constants of the power event manager.
// No dependencies; imported by every module of the block.
`default_nettype none

package pem_pkg;

  // Event ring geometry
  localparam int unsigned RING_ADDR_BITS = 3;
  localparam int unsigned RING_DEPTH     = 1 << RING_ADDR_BITS;
  typedef logic [RING_ADDR_BITS-1:0] ring_ptr_t;

  // Two-entry queues between the parts
  localparam int unsigned QUEUE_DEPTH = 2;
  typedef logic [1:0] qcnt_t;

  // Event codes
  localparam logic [7:0] EV_NONE         = 8'd0;
  localparam logic [7:0] EV_OFF          = 8'd1;
  localparam logic [7:0] EV_IDLE         = 8'd2;
  localparam logic [7:0] EV_BUTTON       = 8'd3;
  localparam logic [7:0] EV_ALARM_SHORT  = 8'd4;
  localparam logic [7:0] EV_ALARM_LONG   = 8'd5;
  localparam logic [7:0] EV_ALARM_CANCEL = 8'd6;

  localparam logic [7:0] IDLE_MAX = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STARTUP_DELAY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_SHORT   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_LONG    = 2'd3;

  localparam logic [15:0] RST_STARTUP_DELAY = 16'd1000;
  localparam logic [7:0]  RST_IDLE_LIMIT    = 8'd27;
  localparam logic [15:0] RST_ALARM_SHORT   = 16'd1000;
  localparam logic [15:0] RST_ALARM_LONG    = 16'd3000;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_POST,
    CMD_POST_ZERO
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] code;
    logic       shown;
  } cmd_t;

  typedef struct packed {
    logic post_accepted;
    logic power_enable;
    logic backlight_one;
    logic backlight_two;
    logic display_reset;
    logic blank_display;
    logic alarm_pulse;
    logic paint_pulse;
    logic button_wait_pulse;
  } res_t;

  typedef struct packed {
    logic [15:0] startup_delay;
    logic [7:0]  idle_limit;
    logic [15:0] alarm_short;
    logic [15:0] alarm_long;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/pem_front.sv
// Front part: classifies incoming words and queues them as commands.
// Depends on pem_pkg.
`default_nettype none

module pem_front
  import pem_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic       op_i,
  input  wire logic [7:0] event_code_i,
  input  wire logic       display_shown_i,
  output logic            full_o,
  output logic            cmd_valid_o,
  output cmd_t            cmd_o,
  input  wire logic       cmd_pop_i
);

  cmd_t  mem_q [QUEUE_DEPTH];
  logic  wr_q, wr_d, rd_q, rd_d;
  qcnt_t cnt_q, cnt_d;
  cmd_t  cmd_in;
  logic  do_push, do_pop;

  // Classify: tick, post, or post of the null code
  always_comb begin
    cmd_in.code  = event_code_i;
    cmd_in.shown = display_shown_i;
    if (!op_i) begin
      cmd_in.kind = CMD_TICK;
    end else if (event_code_i == EV_NONE) begin
      cmd_in.kind = CMD_POST_ZERO;
    end else begin
      cmd_in.kind = CMD_POST;
    end
  end

  assign full_o      = (cnt_q == qcnt_t'(QUEUE_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + qcnt_t'(do_push) - qcnt_t'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pem_back.sv
// Back part: executes commands against the event ring and power state.
// Depends on pem_pkg.
`default_nettype none

module pem_back
  import pem_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  input  wire logic res_ready_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output res_t      res_o
);

  logic [7:0]  ring_q [RING_DEPTH];
  ring_ptr_t   head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
  logic [16:0] startup_q, startup_d;
  logic [7:0]  idle_q, idle_d, idle_v;
  logic [15:0] alarm_q, alarm_d, alarm_v;
  logic        power_q, power_d, bl1_q, bl1_d, bl2_q, bl2_d, dis_q, dis_d;
  logic        wr_en;
  logic [7:0]  wr_data, ev;
  logic        fire;

  assign fire        = cmd_valid_i && res_ready_i;
  assign cmd_pop_o   = fire;
  assign res_valid_o = fire;
  assign head_inc    = head_q + ring_ptr_t'(1);
  assign tail_inc    = tail_q + ring_ptr_t'(1);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    startup_d = startup_q;
    idle_d    = idle_q;
    idle_v    = idle_q;
    alarm_d   = alarm_q;
    alarm_v   = alarm_q;
    power_d   = power_q;
    bl1_d     = bl1_q;
    bl2_d     = bl2_q;
    dis_d     = dis_q;
    wr_en     = 1'b0;
    wr_data   = cmd_i.code;
    ev        = EV_NONE;
    res_o     = '0;

    case (cmd_i.kind)
      CMD_POST_ZERO: begin
        res_o.post_accepted = 1'b1;
      end
      CMD_POST: begin
        if (head_inc != tail_q) begin
          wr_en               = 1'b1;
          head_d              = head_inc;
          res_o.post_accepted = 1'b1;
        end
      end
      CMD_TICK: begin
        if (startup_q > {1'b0, cfg_i.startup_delay}) begin
          // Working phase: at most one event per tick
          if (head_q != tail_q) begin
            ev     = ring_q[tail_q];
            tail_d = tail_inc;
          end
          case (ev)
            EV_OFF: begin
              power_d             = 1'b0;
              bl1_d               = 1'b0;
              bl2_d               = 1'b0;
              dis_d               = 1'b1;
              res_o.blank_display = 1'b1;
            end
            EV_IDLE: begin
              idle_v = (idle_q != IDLE_MAX) ? idle_q + 8'd1 : idle_q;
              idle_d = idle_v;
              if (idle_v == cfg_i.idle_limit) begin
                bl2_d = 1'b0;
              end else if (idle_v > cfg_i.idle_limit) begin
                // Queue power-off; dropped if the ring is full
                if (head_inc != tail_d) begin
                  wr_en   = 1'b1;
                  wr_data = EV_OFF;
                  head_d  = head_inc;
                end
              end
            end
            EV_BUTTON: begin
              idle_d = '0;
              if (cmd_i.shown) begin
                bl2_d = 1'b1;
              end
            end
            EV_ALARM_SHORT:  alarm_v = cfg_i.alarm_short;
            EV_ALARM_LONG:   alarm_v = cfg_i.alarm_long;
            EV_ALARM_CANCEL: alarm_v = '0;
            default: ;
          endcase
          if (alarm_v != '0) begin
            alarm_v           = alarm_v - 16'd1;
            res_o.alarm_pulse = (alarm_v == '0);
          end
          alarm_d = alarm_v;
        end else if (startup_q < {1'b0, cfg_i.startup_delay}) begin
          startup_d = startup_q + 17'd1;
        end else begin
          // Power-on step
          startup_d               = startup_q + 17'd1;
          power_d                 = 1'b1;
          bl1_d                   = 1'b1;
          bl2_d                   = 1'b1;
          res_o.paint_pulse       = 1'b1;
          res_o.button_wait_pulse = 1'b1;
        end
      end
      default: ;
    endcase

    res_o.power_enable  = power_d;
    res_o.backlight_one = bl1_d;
    res_o.backlight_two = bl2_d;
    res_o.display_reset = dis_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      startup_q <= '0;
      idle_q    <= '0;
      alarm_q   <= '0;
      power_q   <= 1'b0;
      bl1_q     <= 1'b0;
      bl2_q     <= 1'b0;
      dis_q     <= 1'b0;
    end else if (fire) begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      startup_q <= startup_d;
      idle_q    <= idle_d;
      alarm_q   <= alarm_d;
      power_q   <= power_d;
      bl1_q     <= bl1_d;
      bl2_q     <= bl2_d;
      dis_q     <= dis_d;
    end
  end

  // Ring entries are written at head only
  always_ff @(posedge clk_i) begin
    if (fire && wr_en) begin
      ring_q[head_q] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pem_result_queue.sv
// Two-entry result queue in front of the output ports.
// Depends on pem_pkg.
`default_nettype none

module pem_result_queue
  import pem_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      ready_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      data_o
);

  res_t  mem_q [QUEUE_DEPTH];
  logic  wr_q, rd_q;
  qcnt_t cnt_q, cnt_d;
  logic  do_push, do_pop;

  assign ready_o = (cnt_q != qcnt_t'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && !empty_o;
  assign cnt_d   = cnt_q + qcnt_t'(do_push) - qcnt_t'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/power_event_manager.sv
// Top level of the power event manager: config registers, front, back, result queue.
// Depends on pem_pkg, pem_front, pem_back, pem_result_queue and the macros header.
//
// Usage:
//  - Input channel is a queue write side: a word (op, event_code, display_shown)
//    is taken at a rising edge with push high and full low. op=0 is a tick,
//    op=1 posts an event code into the 8-slot event ring.
//  - Result channel is a queue read side: while empty is low the oldest result
//    word sits on the result ports; it is taken at an edge with pop high.
//    Every input word yields exactly one result word, in order.
//  - Throughput: one word per cycle while results are popped; the back part
//    executes one command per cycle, updating ring and counters together.
//  - Stall: the two-entry result queue fills first, then the back part holds,
//    the two-entry command queue fills and full rises; at most four words are
//    in flight. Nothing is dropped.
//  - Config: plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user must
//    write it only while the block is idle, which the block does not enforce.
//    Index 0 startup delay, 1 idle limit (low 8 bits), 2 short alarm, 3 long alarm.
//  - Reset: asynchronous, active low; queues empty, ring empty, counters zero,
//    power state off with the display reset line released, registers at defaults.
`default_nettype none
`include "power_event_manager_macros.svh"

module power_event_manager
  import pem_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  // input words
  input  wire logic                     push,
  output logic                          full,
  input  wire logic                     op_i,
  input  wire logic [7:0]               event_code_i,
  input  wire logic                     display_shown_i,
  // result words
  output logic                          empty,
  input  wire logic                     pop,
  output logic                          post_accepted_o,
  output logic                          power_enable_o,
  output logic                          backlight_one_o,
  output logic                          backlight_two_o,
  output logic                          display_reset_o,
  output logic                          blank_display_o,
  output logic                          alarm_pulse_o,
  output logic                          paint_pulse_o,
  output logic                          button_wait_pulse_o
);

  cfg_t cfg_q, cfg_d;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  logic res_valid, res_ready;
  res_t res_back, res_head;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STARTUP_DELAY: cfg_d.startup_delay = cfg_wdata_i;
        CFG_IDLE_LIMIT:    cfg_d.idle_limit    = cfg_wdata_i[7:0];
        CFG_ALARM_SHORT:   cfg_d.alarm_short   = cfg_wdata_i;
        CFG_ALARM_LONG:    cfg_d.alarm_long    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_delay <= RST_STARTUP_DELAY;
      cfg_q.idle_limit    <= RST_IDLE_LIMIT;
      cfg_q.alarm_short   <= RST_ALARM_SHORT;
      cfg_q.alarm_long    <= RST_ALARM_LONG;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: classify and queue
  pem_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .op_i            (op_i),
    .event_code_i    (event_code_i),
    .display_shown_i (display_shown_i),
    .full_o          (full),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Back: ring, startup, idle and alarm handling
  pem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .res_ready_i (res_ready),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res_back)
  );

  // Result queue decouples the receiver
  pem_result_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_back),
    .ready_o (res_ready),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_head)
  );

  assign post_accepted_o     = res_head.post_accepted;
  assign power_enable_o      = res_head.power_enable;
  assign backlight_one_o     = res_head.backlight_one;
  assign backlight_two_o     = res_head.backlight_two;
  assign display_reset_o     = res_head.display_reset;
  assign blank_display_o     = res_head.blank_display;
  assign alarm_pulse_o       = res_head.alarm_pulse;
  assign paint_pulse_o       = res_head.paint_pulse;
  assign button_wait_pulse_o = res_head.button_wait_pulse;

  // Back never executes without a command or without result space
  `PEM_ASSERT_NOW(a_exec_has_cmd, res_valid, cmd_valid && res_ready, "exec without cmd or space")
  // A taken word is visible to the back part on the next cycle
  `PEM_ASSERT_NEXT(a_push_lands, push && !full, cmd_valid, "accepted word lost in front")
  // An executed command leaves a result to pop
  `PEM_ASSERT_NEXT(a_result_lands, res_valid, !empty, "executed result lost")

endmodule

`default_nettype wire
